// ----- hw/rtl/rad_pkg.sv -----
// Shared types and constants for the region address decoder with RAM.
// Used by rad_front, rad_queue, rad_back and the top level; no dependencies.
`timescale 1ns / 1ps

package rad_pkg;

	localparam int REGION_SLOTS_DEF = 4;
	localparam int RAM_ADDRESS_BITS_DEF = 16;

	// Number of region registers in the configuration map.
	localparam int REGION_REGS = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 57;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_COUNT = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_ZERO = 3'd1;

	// Access kind: bit 1 marks a write, bit 0 marks a word.
	localparam logic [1:0] REQ_READ_BYTE = 2'd0;
	localparam logic [1:0] REQ_READ_WORD = 2'd1;
	localparam logic [1:0] REQ_WRITE_BYTE = 2'd2;
	localparam logic [1:0] REQ_WRITE_WORD = 2'd3;
	localparam int KIND_WRITE_BIT = 1;
	localparam int KIND_WORD_BIT = 0;

	localparam logic [1:0] ST_RAM = 2'd0;
	localparam logic [1:0] ST_DEVICE = 2'd1;
	localparam logic [1:0] ST_NO_MATCH = 2'd2;

	typedef struct packed {
		logic        dev_flag;
		logic [7:0]  device;
		logic [15:0] remap;
		logic [15:0] limit;
		logic [15:0] base;
	} region_t;

	// One classified access, handed from the front to the back.
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  device_number;
		logic [15:0] offset;
		logic [1:0]  kind;
		logic [15:0] write_value;
	} entry_t;

endpackage

// ----- hw/rtl/rad_front.sv -----
// Front end: region registers, parallel region match and access classification.
// Depends on rad_pkg.
`timescale 1ns / 1ps

module rad_front #(
	parameter int REGION_SLOTS = rad_pkg::REGION_SLOTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write_en,
	input  logic [rad_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [rad_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             req_type,
	input  logic [15:0]                            address,
	input  logic [15:0]                            write_value,
	output logic                                   push_valid,
	input  logic                                   push_ready,
	output rad_pkg::entry_t                        push_data
);

	localparam int NREG = (REGION_SLOTS < rad_pkg::REGION_REGS) ? REGION_SLOTS
		: rad_pkg::REGION_REGS;
	localparam logic [2:0] NREG_W = 3'(NREG);

	logic [2:0]       count_q;
	rad_pkg::region_t region_q [NREG];
	logic [2:0]       usable;
	logic             hit;
	rad_pkg::region_t sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < NREG; k++) begin
				region_q[k] <= '0;
			end
		end else if (cfg_write_en) begin
			if (cfg_index == rad_pkg::CFG_REGION_COUNT) begin
				count_q <= cfg_data[2:0];
			end
			for (int k = 0; k < NREG; k++) begin
				if (cfg_index == 3'(k) + rad_pkg::CFG_REGION_ZERO) begin
					region_q[k] <= rad_pkg::region_t'(cfg_data);
				end
			end
		end
	end

	assign usable = (count_q < NREG_W) ? count_q : NREG_W;

	// The highest-numbered matching region wins, so later slots override.
	always_comb begin
		hit = 1'b0;
		sel = '0;
		for (int k = 0; k < NREG; k++) begin
			if (3'(k) < usable && address >= region_q[k].base
					&& address <= region_q[k].limit) begin
				hit = 1'b1;
				sel = region_q[k];
			end
		end
	end

	always_comb begin
		push_data.status = !hit ? rad_pkg::ST_NO_MATCH
			: (sel.dev_flag ? rad_pkg::ST_DEVICE : rad_pkg::ST_RAM);
		push_data.device_number = sel.device;
		push_data.offset = address - sel.remap;
		push_data.kind = req_type;
		if (!req_type[rad_pkg::KIND_WRITE_BIT]) begin
			push_data.write_value = '0;
		end else if (req_type[rad_pkg::KIND_WORD_BIT]) begin
			push_data.write_value = write_value;
		end else begin
			push_data.write_value = {8'h00, write_value[7:0]};
		end
	end

	assign push_valid = in_valid;
	assign in_ready = push_ready;

endmodule

// ----- hw/rtl/rad_queue.sv -----
// Two-entry queue of classified words between the front and the back.
// Depends on rad_pkg.
`timescale 1ns / 1ps

module rad_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rad_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rad_pkg::entry_t pop_data
);

	rad_pkg::entry_t slot_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/rad_back.sv -----
// Back end: byte store in two interleaved banks, RAM access and the result register.
// Depends on rad_pkg.
`timescale 1ns / 1ps

module rad_back #(
	parameter int RAM_ADDRESS_BITS = rad_pkg::RAM_ADDRESS_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  rad_pkg::entry_t pop_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      status,
	output logic [15:0]     read_value,
	output logic [7:0]      device_number,
	output logic [15:0]     device_offset,
	output logic [1:0]      device_access,
	output logic [15:0]     device_write_value
);

	localparam int ROW_BITS = RAM_ADDRESS_BITS - 1;
	localparam int ROWS = 2 ** ROW_BITS;

	// Even bytes live in bank0, odd bytes in bank1, so a word touches each bank once.
	logic [7:0] bank0 [ROWS];
	logic [7:0] bank1 [ROWS];

	logic                        pop;
	logic                        out_free;
	logic [RAM_ADDRESS_BITS-1:0] a0;
	logic [RAM_ADDRESS_BITS-1:0] a1;
	logic [ROW_BITS-1:0]         row0;
	logic [ROW_BITS-1:0]         row1;
	logic                        is_ram;
	logic                        is_write;
	logic                        is_word;
	logic                        we0;
	logic                        we1;
	logic [7:0]                  wd0;
	logic [7:0]                  wd1;

	logic            s1_valid_q;
	rad_pkg::entry_t entry_s1;
	logic            swap_s1;
	logic [7:0]      rd0_s1;
	logic [7:0]      rd1_s1;
	logic [7:0]      lo_byte;
	logic [7:0]      hi_byte;
	logic [15:0]     ram_value;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [15:0]     read_value_q;
	logic [7:0]      device_number_q;
	logic [15:0]     device_offset_q;
	logic [1:0]      device_access_q;
	logic [15:0]     device_write_value_q;

	assign out_free = !out_valid_q || out_ready;
	assign pop_ready = !s1_valid_q || out_free;
	assign pop = pop_valid && pop_ready;

	assign a0 = pop_data.offset[RAM_ADDRESS_BITS-1:0];
	assign a1 = a0 + RAM_ADDRESS_BITS'(1);
	assign row0 = a0[0] ? a1[RAM_ADDRESS_BITS-1:1] : a0[RAM_ADDRESS_BITS-1:1];
	assign row1 = a0[RAM_ADDRESS_BITS-1:1];

	assign is_ram = (pop_data.status == rad_pkg::ST_RAM);
	assign is_write = pop_data.kind[rad_pkg::KIND_WRITE_BIT];
	assign is_word = pop_data.kind[rad_pkg::KIND_WORD_BIT];
	assign we0 = pop && is_ram && is_write && (!a0[0] || is_word);
	assign we1 = pop && is_ram && is_write && (a0[0] || is_word);
	assign wd0 = a0[0] ? pop_data.write_value[15:8] : pop_data.write_value[7:0];
	assign wd1 = a0[0] ? pop_data.write_value[7:0] : pop_data.write_value[15:8];

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0[row0] <= wd0;
		end
		if (pop) begin
			rd0_s1 <= bank0[row0];
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			bank1[row1] <= wd1;
		end
		if (pop) begin
			rd1_s1 <= bank1[row1];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_s1 <= pop_data;
			swap_s1 <= a0[0];
		end
	end

	assign lo_byte = swap_s1 ? rd1_s1 : rd0_s1;
	assign hi_byte = swap_s1 ? rd0_s1 : rd1_s1;

	always_comb begin
		if (entry_s1.kind[rad_pkg::KIND_WRITE_BIT]) begin
			ram_value = '0;
		end else if (entry_s1.kind[rad_pkg::KIND_WORD_BIT]) begin
			ram_value = {hi_byte, lo_byte};
		end else begin
			ram_value = {8'h00, lo_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				s1_valid_q <= pop_valid;
			end
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			status_q <= entry_s1.status;
			read_value_q <= '0;
			device_number_q <= '0;
			device_offset_q <= '0;
			device_access_q <= '0;
			device_write_value_q <= '0;
			unique case (entry_s1.status)
				rad_pkg::ST_RAM: begin
					read_value_q <= ram_value;
				end
				rad_pkg::ST_DEVICE: begin
					device_number_q <= entry_s1.device_number;
					device_offset_q <= entry_s1.offset;
					device_access_q <= entry_s1.kind;
					device_write_value_q <= entry_s1.write_value;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign read_value = read_value_q;
	assign device_number = device_number_q;
	assign device_offset = device_offset_q;
	assign device_access = device_access_q;
	assign device_write_value = device_write_value_q;

endmodule

// ----- hw/rtl/region_address_decoder_with_ram_core.sv -----
// Top level of the region address decoder with internal byte RAM.
// Depends on rad_pkg, rad_front, rad_queue and rad_back.
`timescale 1ns / 1ps

// Usage:
// Bus accesses arrive on the input channel (in_valid/in_ready with req_type,
// address and write_value) and each produces exactly one result word on the
// output channel (out_valid/out_ready). Regions are set through the write
// port: index 0 holds the region count, indexes 1 to 4 hold the regions.
// Write the registers only while no access is in flight.
// The front compares the address against all regions at once and places the
// classified word in a two-entry queue in the same cycle it is accepted. The
// back pops one word per cycle unless the output stalls, accesses the two
// byte banks (even and odd bytes) and registers the result. A result passes
// the queue, the back stage and the result register; one access per cycle is
// sustained while the receiver keeps up, as each access uses each RAM bank once.
// When the receiver stalls, the result register holds, then the back stage,
// then the queue fills, and in_ready falls once all three are full.
// Reset clears the region registers and all handshake state; the RAM keeps
// its contents and is undefined until written, so it needs no clearing pass.
module region_address_decoder_with_ram_core #(
	parameter int REGION_SLOTS = rad_pkg::REGION_SLOTS_DEF,
	parameter int RAM_ADDRESS_BITS = rad_pkg::RAM_ADDRESS_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [rad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rad_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [15:0]                        address,
	input  logic [15:0]                        write_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic [15:0]                        read_value,
	output logic [7:0]                         device_number,
	output logic [15:0]                        device_offset,
	output logic [1:0]                         device_access,
	output logic [15:0]                        device_write_value
);

	logic            push_valid;
	logic            push_ready;
	rad_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	rad_pkg::entry_t pop_data;

	rad_front #(
		.REGION_SLOTS(REGION_SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.address(address),
		.write_value(write_value),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	rad_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	rad_back #(
		.RAM_ADDRESS_BITS(RAM_ADDRESS_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.read_value(read_value),
		.device_number(device_number),
		.device_offset(device_offset),
		.device_access(device_access),
		.device_write_value(device_write_value)
	);

	// An accepted access is always waiting in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> pop_valid)
		else $error("Accepted access did not reach the queue.");

	// Device fields are zero unless the word is forwarded to a device.
	a_device_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rad_pkg::ST_DEVICE |-> device_number == 8'h00
			&& device_offset == 16'h0000 && device_access == 2'b00
			&& device_write_value == 16'h0000)
		else $error("Device fields set on a word that is not forwarded.");

	// Read data only comes from the RAM path.
	a_read_value_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rad_pkg::ST_RAM |-> read_value == 16'h0000)
		else $error("Read data set on a word not served by RAM.");

endmodule
